>>> src/segment_box_nearest_hit_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the segment box nearest hit unit
// Shared forms for the concurrent checks of the design.
// ---------------------------------------------------------------------------
`ifndef SEGMENT_BOX_NEAREST_HIT_UNIT_MACROS_SVH
`define SEGMENT_BOX_NEAREST_HIT_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBNH_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBNH_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/sbnh_pkg.sv
// ---------------------------------------------------------------------------
// sbnh_pkg
// Types and constants shared by the segment box nearest hit unit.
// ---------------------------------------------------------------------------
package sbnh_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_BOX_RD,
        ST_AXIS,
        ST_DIV_LO_WAIT,
        ST_DIV_HI,
        ST_DIV_HI_WAIT,
        ST_SLAB,
        ST_BOX_END,
        ST_GROUND,
        ST_GROUND_WAIT,
        ST_POINT,
        ST_OUT
    } sbnh_state_t;

    typedef enum logic {
        SS_DIV,
        SS_SQRT
    } ss_mode_t;

    typedef struct packed {
        logic       start;
        ss_mode_t   mode;
        logic [5:0] steps;
    } ss_ctrl_t;

    typedef struct packed {
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] min_z;
        logic signed [31:0] max_x;
        logic signed [31:0] max_y;
        logic signed [31:0] max_z;
        logic [2:0]         mat;
    } box_entry_t;

    localparam int REM_W  = 40;
    localparam int FEED_W = 72;
    localparam int QUOT_W = 36;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_CAST = 1'b1;

    localparam logic [1:0] REG_BOX_COUNT  = 2'd0;
    localparam logic [1:0] REG_GROUND_MAT = 2'd1;

    localparam logic [2:0] FACE_NONE  = 3'd0;
    localparam logic [2:0] FACE_NEG_X = 3'd1;
    localparam logic [2:0] FACE_POS_Y = 3'd4;

    localparam logic [17:0]        NO_HIT_T   = 18'd131072;
    localparam logic signed [19:0] ONE_T      = 20'sd65536;
    localparam logic [19:0]        T_SAT      = 20'd262144;
    localparam logic [5:0]         DIV_STEPS  = 6'd18;
    localparam logic [5:0]         SQRT_STEPS = 6'd36;
    localparam logic [30:0]        THICK_MAX  = 31'h7FFF_FFFF;

endpackage

>>> src/segment_box_nearest_hit_unit.sv
// ---------------------------------------------------------------------------
// segment_box_nearest_hit_unit
// Nearest hit of a 3D segment against a box table and the ground plane.
// ---------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_stall) carries load and cast items.
// A load item (func 0) writes one box into the table and gives no result.
// A cast item (func 1) gives exactly one result on the
// output channel (out_valid, out_stall).
// A cast finds the segment length with a square root, tests each box taking
// part and then the ground, works out the hit point and fills the output
// register. The shared shift and subtract unit resolves one quotient bit or
// one root bit a cycle and does up to two divisions per axis of every box.
// in_stall is high while a cast is being worked on. A finished result sits
// in the output register while the next item is taken; if the receiver
// still stalls when the following cast finishes, the block waits for the
// register to empty. Reset clears both configuration registers and the
// sequencer; the box table keeps no reset value and must be loaded.
// Configuration writes must only be made while the block is idle.
// ---------------------------------------------------------------------------
`include "segment_box_nearest_hit_unit_macros.svh"

module segment_box_nearest_hit_unit
    import sbnh_pkg::*;
#(
    parameter int MAX_BOXES = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [5:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               func,
    input  logic [4:0]         box_index,
    input  logic signed [31:0] first_x,
    input  logic signed [31:0] first_y,
    input  logic signed [31:0] first_z,
    input  logic signed [31:0] second_x,
    input  logic signed [31:0] second_y,
    input  logic signed [31:0] second_z,
    input  logic [2:0]         box_material,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               hit,
    output logic [17:0]        entry_t,
    output logic [16:0]        exit_t,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic signed [31:0] point_z,
    output logic [2:0]         face,
    output logic [2:0]         hit_material,
    output logic [5:0]         hit_index,
    output logic [30:0]        thickness
);

    localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CW = $clog2(MAX_BOXES + 1);
    localparam logic [5:0] GROUND_IDX = 6'(MAX_BOXES);

    sbnh_state_t state_reg, state_next;

    logic [5:0] box_count_reg;
    logic [2:0] ground_mat_reg;

    logic signed [31:0] a_x_reg, a_y_reg, a_z_reg;
    logic signed [32:0] d_x_reg, d_y_reg, d_z_reg;
    logic [65:0]        sum_reg;
    logic [32:0]        len_reg;
    logic [2:0]         cnt_reg;
    logic [CW-1:0]      box_i_reg;
    logic [1:0]         axis_reg;
    logic signed [19:0] tmin_reg, tmax_reg, t1_reg;
    logic [2:0]         face_reg;
    logic               passed_reg;
    logic               neg_reg, ovf_reg;

    logic               best_hit_reg, ground_reg;
    logic [17:0]        best_t_reg;
    logic [16:0]        best_exit_reg;
    logic [2:0]         best_face_reg, best_mat_reg;
    logic [5:0]         best_idx_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic [30:0]        thick_reg;

    logic               out_valid_reg;
    logic               hit_reg;
    logic [17:0]        entry_t_reg;
    logic [16:0]        exit_t_reg;
    logic signed [31:0] point_x_reg, point_y_reg, point_z_reg;
    logic [2:0]         face_out_reg, mat_out_reg;
    logic [5:0]         index_out_reg;
    logic [30:0]        thick_out_reg;

    logic in_accept;
    logic slot_free;
    logic [CW-1:0] n_boxes;

    box_entry_t ent, wr_ent;
    logic       mem_we;

    logic signed [31:0] o_sel, lo_sel, hi_sel, bound;
    logic signed [32:0] d_sel;
    logic signed [33:0] num_s;
    logic signed [32:0] den_s;
    logic [33:0]        num_mag;
    logic [32:0]        den_mag;
    logic               div_ovf, div_neg;
    logic               zero_pass, ground_cross;

    ss_ctrl_t            ss_ctrl;
    logic [REM_W-1:0]    ss_init_rem, ss_divisor;
    logic [FEED_W-1:0]   ss_feed;
    logic [QUOT_W-1:0]   ss_quot;
    logic                ss_done;

    logic [19:0]        t_mag;
    logic signed [19:0] t_cur;
    logic               swap, slab_miss;
    logic signed [19:0] near_t, far_t, ntmin, ntmax;
    logic [2:0]         face_neg, face_pos, near_face, nface;

    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] prod;
    logic signed [67:0] prod_q16;
    logic [17:0]        t_span;

    assign in_accept = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign n_boxes   = (32'(box_count_reg) > MAX_BOXES) ? CW'(MAX_BOXES) : CW'(box_count_reg);

    // Box table
    assign mem_we = in_accept && (func == FUNC_LOAD) && (32'(box_index) < MAX_BOXES);
    assign wr_ent = '{min_x: first_x, min_y: first_y, min_z: first_z,
                      max_x: second_x, max_y: second_y, max_z: second_z,
                      mat: box_material};

    sbnh_box_mem #(
        .DEPTH (MAX_BOXES),
        .AW    (AW)
    ) u_box_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (AW'(box_index)),
        .wdata (wr_ent),
        .raddr (AW'(box_i_reg)),
        .rdata (ent)
    );

    // Operands of the slab division for the current axis, or of the ground division.
    always_comb
    begin
        case (axis_reg)
            2'd0:
            begin
                o_sel = a_x_reg; d_sel = d_x_reg; lo_sel = ent.min_x; hi_sel = ent.max_x;
            end
            2'd1:
            begin
                o_sel = a_y_reg; d_sel = d_y_reg; lo_sel = ent.min_y; hi_sel = ent.max_y;
            end
            default:
            begin
                o_sel = a_z_reg; d_sel = d_z_reg; lo_sel = ent.min_z; hi_sel = ent.max_z;
            end
        endcase
        bound = (state_reg == ST_DIV_HI) ? hi_sel : lo_sel;
        if (state_reg == ST_GROUND)
        begin
            num_s = {{2{a_y_reg[31]}}, a_y_reg};
            den_s = -d_y_reg;
        end
        else
        begin
            num_s = {{2{bound[31]}}, bound} - {{2{o_sel[31]}}, o_sel};
            den_s = d_sel;
        end
        num_mag = num_s[33] ? 34'(-num_s) : 34'(num_s);
        den_mag = den_s[32] ? 33'(-den_s) : 33'(den_s);
        // The quotient only matters against 0 and 1.0, so anything of 4.0
        // and above is held at 4.0 without changing any outcome.
        div_ovf = {1'b0, num_mag} >= {den_mag, 2'b00};
        div_neg = num_s[33] ^ den_s[32];
        zero_pass    = (o_sel >= lo_sel) && (o_sel <= hi_sel);
        ground_cross = !a_y_reg[31] && ((33'(a_y_reg) + d_y_reg) < 0);
    end

    assign t_mag = ovf_reg ? T_SAT : {2'b00, ss_quot[17:0]};
    assign t_cur = neg_reg ? -$signed(t_mag) : $signed(t_mag);

    // Slab update
    always_comb
    begin
        face_neg  = FACE_NEG_X + 3'({axis_reg, 1'b0});
        face_pos  = face_neg + 3'd1;
        swap      = t1_reg > t_cur;
        near_t    = swap ? t_cur : t1_reg;
        far_t     = swap ? t1_reg : t_cur;
        near_face = swap ? face_pos : face_neg;
        if (near_t > tmin_reg)
        begin
            ntmin = near_t;
            nface = near_face;
        end
        else
        begin
            ntmin = tmin_reg;
            nface = face_reg;
        end
        ntmax     = (far_t < tmax_reg) ? far_t : tmax_reg;
        slab_miss = ntmin > ntmax;
    end

    sbnh_shift_sub u_shift_sub (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ss_ctrl),
        .init_rem (ss_init_rem),
        .feed     (ss_feed),
        .divisor  (ss_divisor),
        .quot     (ss_quot),
        .done     (ss_done)
    );

    // Multiplier operands
    assign t_span = {1'b0, best_exit_reg} - best_t_reg;
    always_comb
    begin
        mul_a = {d_x_reg[32], d_x_reg};
        mul_b = {d_x_reg[32], d_x_reg};
        if (state_reg == ST_SQ)
        begin
            case (cnt_reg)
                3'd1:
                begin
                    mul_a = {d_y_reg[32], d_y_reg}; mul_b = {d_y_reg[32], d_y_reg};
                end
                3'd2:
                begin
                    mul_a = {d_z_reg[32], d_z_reg}; mul_b = {d_z_reg[32], d_z_reg};
                end
                default:
                begin
                    mul_a = {d_x_reg[32], d_x_reg}; mul_b = {d_x_reg[32], d_x_reg};
                end
            endcase
        end
        else
        begin
            case (cnt_reg)
                3'd1:
                begin
                    mul_a = {d_y_reg[32], d_y_reg}; mul_b = {16'd0, best_t_reg};
                end
                3'd2:
                begin
                    mul_a = {d_z_reg[32], d_z_reg}; mul_b = {16'd0, best_t_reg};
                end
                3'd3:
                begin
                    mul_a = {1'b0, len_reg}; mul_b = {16'd0, t_span};
                end
                default:
                begin
                    mul_a = {d_x_reg[32], d_x_reg}; mul_b = {16'd0, best_t_reg};
                end
            endcase
        end
    end

    sbnh_mult u_mult (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    assign prod_q16 = prod >>> 16;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (func == FUNC_CAST))
                begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                if (cnt_reg == 3'd3)
                begin
                    state_next = ST_SQRT_GO;
                end
            end
            ST_SQRT_GO:
            begin
                state_next = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT:
            begin
                if (ss_done)
                begin
                    state_next = (n_boxes == '0) ? ST_GROUND : ST_BOX_RD;
                end
            end
            ST_BOX_RD:
            begin
                state_next = ST_AXIS;
            end
            ST_AXIS:
            begin
                if (d_sel != '0)
                begin
                    state_next = ST_DIV_LO_WAIT;
                end
                else if (!zero_pass || (axis_reg == 2'd2))
                begin
                    state_next = ST_BOX_END;
                end
            end
            ST_DIV_LO_WAIT:
            begin
                if (ss_done)
                begin
                    state_next = ST_DIV_HI;
                end
            end
            ST_DIV_HI:
            begin
                state_next = ST_DIV_HI_WAIT;
            end
            ST_DIV_HI_WAIT:
            begin
                if (ss_done)
                begin
                    state_next = ST_SLAB;
                end
            end
            ST_SLAB:
            begin
                state_next = (slab_miss || (axis_reg == 2'd2)) ? ST_BOX_END : ST_AXIS;
            end
            ST_BOX_END:
            begin
                state_next = (CW'(box_i_reg + 1'b1) == n_boxes) ? ST_GROUND : ST_BOX_RD;
            end
            ST_GROUND:
            begin
                state_next = ground_cross ? ST_GROUND_WAIT : ST_POINT;
            end
            ST_GROUND_WAIT:
            begin
                if (ss_done)
                begin
                    state_next = ST_POINT;
                end
            end
            ST_POINT:
            begin
                if (!best_hit_reg || (cnt_reg == 3'd4))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        in_stall      = (state_reg != ST_IDLE);
        ss_ctrl.start = 1'b0;
        ss_ctrl.mode  = SS_DIV;
        ss_ctrl.steps = DIV_STEPS;
        ss_init_rem   = REM_W'(num_mag[33:2]);
        ss_feed       = {num_mag[1:0], {(FEED_W-2){1'b0}}};
        ss_divisor    = REM_W'(den_mag);
        case (state_reg)
            ST_SQRT_GO:
            begin
                ss_ctrl.start = 1'b1;
                ss_ctrl.mode  = SS_SQRT;
                ss_ctrl.steps = SQRT_STEPS;
                ss_init_rem   = '0;
                ss_feed       = FEED_W'(sum_reg);
            end
            ST_AXIS:
            begin
                ss_ctrl.start = (d_sel != '0);
            end
            ST_DIV_HI:
            begin
                ss_ctrl.start = 1'b1;
            end
            ST_GROUND:
            begin
                ss_ctrl.start = ground_cross;
            end
            default:
            begin
                ss_ctrl.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            box_count_reg  <= '0;
            ground_mat_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we && (cfg_index == REG_BOX_COUNT))
            begin
                box_count_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == REG_GROUND_MAT))
            begin
                ground_mat_reg <= cfg_data[2:0];
            end
            if (state_reg == ST_OUT && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                a_x_reg       <= first_x;
                a_y_reg       <= first_y;
                a_z_reg       <= first_z;
                d_x_reg       <= {second_x[31], second_x} - {first_x[31], first_x};
                d_y_reg       <= {second_y[31], second_y} - {first_y[31], first_y};
                d_z_reg       <= {second_z[31], second_z} - {first_z[31], first_z};
                sum_reg       <= '0;
                cnt_reg       <= '0;
                best_hit_reg  <= 1'b0;
                ground_reg    <= 1'b0;
                best_t_reg    <= NO_HIT_T;
                best_exit_reg <= '0;
                best_face_reg <= FACE_NONE;
                best_mat_reg  <= '0;
                best_idx_reg  <= '0;
                px_reg        <= '0;
                py_reg        <= '0;
                pz_reg        <= '0;
                thick_reg     <= '0;
            end
            ST_SQ:
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg != 3'd0)
                begin
                    sum_reg <= sum_reg + prod[65:0];
                end
            end
            ST_SQRT_WAIT:
            begin
                len_reg   <= ss_quot[32:0];
                box_i_reg <= '0;
            end
            ST_BOX_RD:
            begin
                axis_reg   <= 2'd0;
                tmin_reg   <= '0;
                tmax_reg   <= ONE_T;
                face_reg   <= FACE_NONE;
                passed_reg <= 1'b0;
            end
            ST_AXIS:
            begin
                neg_reg <= div_neg;
                ovf_reg <= div_ovf;
                if (d_sel == '0)
                begin
                    if (!zero_pass)
                    begin
                        passed_reg <= 1'b0;
                    end
                    else if (axis_reg == 2'd2)
                    begin
                        passed_reg <= 1'b1;
                    end
                    else
                    begin
                        axis_reg <= axis_reg + 2'd1;
                    end
                end
            end
            ST_DIV_LO_WAIT:
            begin
                t1_reg <= t_cur;
            end
            ST_DIV_HI:
            begin
                neg_reg <= div_neg;
                ovf_reg <= div_ovf;
            end
            ST_SLAB:
            begin
                tmin_reg <= ntmin;
                tmax_reg <= ntmax;
                face_reg <= nface;
                if (slab_miss)
                begin
                    passed_reg <= 1'b0;
                end
                else if (axis_reg == 2'd2)
                begin
                    passed_reg <= 1'b1;
                end
                else
                begin
                    axis_reg <= axis_reg + 2'd1;
                end
            end
            ST_BOX_END:
            begin
                // Strictly smaller entry only, so the first box wins a tie.
                if (passed_reg && (tmin_reg < $signed({2'b00, best_t_reg})))
                begin
                    best_hit_reg  <= 1'b1;
                    best_t_reg    <= tmin_reg[17:0];
                    best_exit_reg <= tmax_reg[16:0];
                    best_face_reg <= face_reg;
                    best_mat_reg  <= ent.mat;
                    best_idx_reg  <= 6'(box_i_reg);
                end
                box_i_reg <= CW'(box_i_reg + 1'b1);
            end
            ST_GROUND:
            begin
                neg_reg <= div_neg;
                ovf_reg <= div_ovf;
                cnt_reg <= '0;
            end
            ST_GROUND_WAIT:
            begin
                cnt_reg <= '0;
                if (ss_done && (t_cur < $signed({2'b00, best_t_reg})))
                begin
                    best_hit_reg  <= 1'b1;
                    ground_reg    <= 1'b1;
                    best_t_reg    <= t_cur[17:0];
                    best_exit_reg <= t_cur[16:0];
                    best_face_reg <= FACE_POS_Y;
                    best_mat_reg  <= ground_mat_reg;
                    best_idx_reg  <= GROUND_IDX;
                end
            end
            ST_POINT:
            begin
                cnt_reg <= cnt_reg + 3'd1;
                case (cnt_reg)
                    3'd1:
                    begin
                        px_reg <= a_x_reg + prod_q16[31:0];
                    end
                    3'd2:
                    begin
                        py_reg <= ground_reg ? 32'sd0 : (a_y_reg + prod_q16[31:0]);
                    end
                    3'd3:
                    begin
                        pz_reg <= a_z_reg + prod_q16[31:0];
                    end
                    3'd4:
                    begin
                        if (ground_reg)
                        begin
                            thick_reg <= '0;
                        end
                        else if (prod_q16 > $signed({37'd0, THICK_MAX}))
                        begin
                            thick_reg <= THICK_MAX;
                        end
                        else
                        begin
                            thick_reg <= prod_q16[30:0];
                        end
                    end
                    default:
                    begin
                        thick_reg <= thick_reg;
                    end
                endcase
            end
            ST_OUT:
            begin
                if (slot_free)
                begin
                    hit_reg       <= best_hit_reg;
                    entry_t_reg   <= best_t_reg;
                    exit_t_reg    <= best_exit_reg;
                    point_x_reg   <= px_reg;
                    point_y_reg   <= py_reg;
                    point_z_reg   <= pz_reg;
                    face_out_reg  <= best_face_reg;
                    mat_out_reg   <= best_mat_reg;
                    index_out_reg <= best_idx_reg;
                    thick_out_reg <= thick_reg;
                end
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign entry_t      = entry_t_reg;
    assign exit_t       = exit_t_reg;
    assign point_x      = point_x_reg;
    assign point_y      = point_y_reg;
    assign point_z      = point_z_reg;
    assign face         = face_out_reg;
    assign hit_material = mat_out_reg;
    assign hit_index    = index_out_reg;
    assign thickness    = thick_out_reg;

    `SBNH_ASSERT_IMP(a_miss_fields, out_valid && !hit, (entry_t == NO_HIT_T) && (face == FACE_NONE) && (thickness == '0), "miss result carries hit fields")
    `SBNH_ASSERT_IMP(a_hit_order, out_valid && hit, entry_t <= {1'b0, exit_t}, "entry parameter beyond exit parameter")
    `SBNH_ASSERT_NXT(a_cast_starts, in_valid && !in_stall && (func == FUNC_CAST), (state_reg == ST_SQ) && in_stall, "cast transfer did not start the sequencer")

endmodule

>>> src/sbnh_box_mem.sv
// ---------------------------------------------------------------------------
// sbnh_box_mem
// Box table: one write port and one registered read port.
// ---------------------------------------------------------------------------
module sbnh_box_mem
    import sbnh_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  box_entry_t    wdata,
    input  logic [AW-1:0] raddr,
    output box_entry_t    rdata
);

    box_entry_t mem [DEPTH];
    box_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/sbnh_shift_sub.sv
// ---------------------------------------------------------------------------
// sbnh_shift_sub
// Shared shift and subtract unit: one quotient bit or one root bit a cycle.
// ---------------------------------------------------------------------------
module sbnh_shift_sub
    import sbnh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ss_ctrl_t          ctrl,
    input  logic [REM_W-1:0]  init_rem,
    input  logic [FEED_W-1:0] feed,
    input  logic [REM_W-1:0]  divisor,
    output logic [QUOT_W-1:0] quot,
    output logic              done
);

    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [FEED_W-1:0] feed_reg, feed_next;
    logic [QUOT_W-1:0] q_reg, q_next;
    logic [REM_W-1:0]  div_reg;
    ss_mode_t          mode_reg;
    logic [5:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;

    // A square root step brings down two bits and tries 4*root+1.
    always_comb
    begin
        if (mode_reg == SS_SQRT)
        begin
            rem_sh    = {rem_reg[REM_W-3:0], feed_reg[FEED_W-1 -: 2]};
            feed_next = {feed_reg[FEED_W-3:0], 2'b00};
            trial     = {2'b00, q_reg, 2'b01};
        end
        else
        begin
            rem_sh    = {rem_reg[REM_W-2:0], feed_reg[FEED_W-1]};
            feed_next = {feed_reg[FEED_W-2:0], 1'b0};
            trial     = div_reg;
        end
        if (rem_sh >= trial)
        begin
            rem_next = rem_sh - trial;
            q_next   = {q_reg[QUOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_sh;
            q_next   = {q_reg[QUOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctrl.steps;
                done_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    done_reg <= 1'b0;
                end
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            rem_reg  <= init_rem;
            feed_reg <= feed;
            div_reg  <= divisor;
            mode_reg <= ctrl.mode;
            q_reg    <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            feed_reg <= feed_next;
            q_reg    <= q_next;
        end
    end

    assign quot = q_reg;
    assign done = done_reg;

endmodule

>>> src/sbnh_mult.sv
// ---------------------------------------------------------------------------
// sbnh_mult
// Shared signed multiplier with a registered product.
// ---------------------------------------------------------------------------
module sbnh_mult
    import sbnh_pkg::*;
(
    input  logic               clk,
    input  logic signed [33:0] op_a,
    input  logic signed [33:0] op_b,
    output logic signed [67:0] prod
);

    logic signed [67:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule
